>>> design/dpod_pkg.sv
// Package for the date period overlap block: field widths, the date record,
// the sequencer states and the calendar tables. Depends on nothing.
package dpod_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned CountW  = 22;
  localparam int unsigned SerialW = 22;

  // Four dates per transaction: A start, A end, B start, B end.
  localparam int unsigned DateCount = 4;
  localparam int unsigned DateIdxW  = $clog2(DateCount);

  localparam logic [YearW-1:0]  YearMin  = YearW'(1);
  localparam logic [YearW-1:0]  YearMax  = YearW'(9999);
  localparam logic [MonthW-1:0] MonthMin = MonthW'(1);
  localparam logic [MonthW-1:0] MonthMax = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [DayW-1:0]   DayMin   = DayW'(1);

  // Shared multiplier operands. floor(y * 5243 / 2^19) equals y / 100 for
  // every year up to 9999.
  localparam int unsigned MulAW   = YearW;
  localparam int unsigned MulBW   = 13;
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned RecipSh = 19;
  localparam int unsigned QuotW   = 7;
  localparam logic [MulBW-1:0] RecipHundred = MulBW'(5243);
  localparam logic [MulBW-1:0] DaysPerYear  = MulBW'(365);
  localparam logic [YearW-1:0] Hundred      = YearW'(100);

  // Small per-date correction terms fit in this width.
  localparam int unsigned PartW = 13;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MULQ,
    ST_LEAP,
    ST_MUL365,
    ST_SUM,
    ST_CMP,
    ST_FINISH
  } dpod_state_e;

  // Days in the month; February depends on the leap flag.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                   len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      default:                len = DayW'(31);
    endcase
    return len;
  endfunction

  // Days in the year before the first of the month (common year).
  function automatic logic [9:0] days_before(input logic [MonthW-1:0] m);
    logic [9:0] d;
    case (m)
      4'd2:    d = 10'd31;
      4'd3:    d = 10'd59;
      4'd4:    d = 10'd90;
      4'd5:    d = 10'd120;
      4'd6:    d = 10'd151;
      4'd7:    d = 10'd181;
      4'd8:    d = 10'd212;
      4'd9:    d = 10'd243;
      4'd10:   d = 10'd273;
      4'd11:   d = 10'd304;
      4'd12:   d = 10'd334;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

endpackage

>>> design/dpod_if.sv
// Handshake interfaces for the date period overlap block: the input channel
// carrying two date periods and the output channel carrying the day count.
// Depends on dpod_pkg.
interface dpod_in_if import dpod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   a_start_day;
  logic [MonthW-1:0] a_start_month;
  logic [YearW-1:0]  a_start_year;
  logic [DayW-1:0]   a_end_day;
  logic [MonthW-1:0] a_end_month;
  logic [YearW-1:0]  a_end_year;
  logic [DayW-1:0]   b_start_day;
  logic [MonthW-1:0] b_start_month;
  logic [YearW-1:0]  b_start_year;
  logic [DayW-1:0]   b_end_day;
  logic [MonthW-1:0] b_end_month;
  logic [YearW-1:0]  b_end_year;

  modport source (
    output valid, a_start_day, a_start_month, a_start_year,
           a_end_day, a_end_month, a_end_year,
           b_start_day, b_start_month, b_start_year,
           b_end_day, b_end_month, b_end_year,
    input  ready
  );
  modport sink (
    input  valid, a_start_day, a_start_month, a_start_year,
           a_end_day, a_end_month, a_end_year,
           b_start_day, b_start_month, b_start_year,
           b_end_day, b_end_month, b_end_year,
    output ready
  );
endinterface

interface dpod_out_if import dpod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] overlap_days;

  modport source (output valid, overlap_days, input ready);
  modport sink (input valid, overlap_days, output ready);
endinterface

>>> design/date_period_overlap_days.sv
// Top level of the date period overlap block: a small sequencer around one
// shared multiplier that turns four dates into serial day numbers.
// Depends on dpod_pkg and the interfaces in dpod_if.sv.
//
//   Channel | Direction | Modport | Carries
//   --------+-----------+---------+------------------------------------------
//   in_i    | in        | sink    | two periods, each a start and end date
//   out_o   | out       | source  | overlap_days, days lying in both periods
//
// Each transaction runs the five-step serial-day sequence for each of the
// four dates in turn, then one step picks the later start and earlier end,
// and one more forms the count. The shared multiplier is used twice per date.
// The input is ready only while the sequencer is idle; the result sits in an
// output register, so a new transaction may be accepted while the previous
// result still waits. Should the output still be full when a count is ready,
// the sequencer holds until it is taken. Reset is asynchronous and active
// low; it clears the sequencer and the output valid flag.
module date_period_overlap_days
  import dpod_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  dpod_in_if.sink        in_i,
  dpod_out_if.source     out_o
);

  // Control state.
  dpod_state_e         state_q, state_d;
  logic [DateIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;

  // Datapath registers.
  date_t                dates_q [DateCount];
  logic [YearW-1:0]     yy_q;
  logic [MonthW-1:0]    mm_q;
  logic [DayW-1:0]      dd_q;
  logic                 leap_q;
  logic [QuotW-1:0]     q1_q;
  logic [PartW-1:0]     part_q;
  logic [MulPW-1:0]     prod_q;
  logic [SerialW-1:0]   serial_q [DateCount];
  logic [SerialW-1:0]   lo_q, hi_q;
  logic [CountW-1:0]    out_q;

  logic accept;
  logic out_free;
  logic load_out;
  logic last_date;

  // Shared multiplier.
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  // Per-step combinational terms.
  date_t             cur;
  logic [YearW-1:0]  yy_clamp;
  logic [MonthW-1:0] mm_clamp;
  logic [YearW-1:0]  y1;
  logic [QuotW-1:0]  qy;
  logic [YearW-1:0]  rem;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic [DayW-1:0]   dd_clamp;
  logic [PartW-1:0]  part;
  logic [SerialW-1:0] lo, hi;
  logic [CountW-1:0] count;

  assign accept    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign last_date = (idx_q == DateIdxW'(DateCount - 1));
  assign load_out  = (state_q == ST_FINISH) && out_free;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.overlap_days = out_q;

  // Sequencer: next state and handshake control.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CLAMP;
          idx_d   = '0;
        end
      end
      ST_CLAMP:  state_d = ST_MULQ;
      ST_MULQ:   state_d = ST_LEAP;
      ST_LEAP:   state_d = ST_MUL365;
      ST_MUL365: state_d = ST_SUM;
      ST_SUM: begin
        idx_d   = idx_q + DateIdxW'(1);
        state_d = last_date ? ST_CMP : ST_CLAMP;
      end
      ST_CMP:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The date under work, with year and month brought into range.
  assign cur      = dates_q[idx_q];
  assign yy_clamp = (cur.year < YearMin) ? YearMin :
                    (cur.year > YearMax) ? YearMax : cur.year;
  assign mm_clamp = (cur.month < MonthMin) ? MonthMin :
                    (cur.month > MonthMax) ? MonthMax : cur.month;

  // The multiplier first forms year / 100 by reciprocal, then 365 * (year - 1).
  assign y1    = yy_q - YearW'(1);
  assign mul_a = (state_q == ST_MUL365) ? y1 : yy_q;
  assign mul_b = (state_q == ST_MUL365) ? DaysPerYear : RecipHundred;
  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  // Leap rule from the quotient by 100: divisible by 4, and either not by
  // 100 or with a quotient that is itself divisible by 4.
  assign qy   = prod_q[RecipSh +: QuotW];
  assign rem  = yy_q - YearW'(qy) * Hundred;
  assign leap = (yy_q[1:0] == 2'b00) && ((rem != '0) || (qy[1:0] == 2'b00));
  assign mlen = month_len(mm_q, leap);
  assign dd_clamp = (dd_q < DayMin) ? DayMin : (dd_q > mlen) ? mlen : dd_q;

  // Everything but 365 * (year - 1): leap days of earlier years, days of
  // earlier months and the day of the month. (year - 1) / 100 is the
  // quotient of the year itself, less one when the year is a whole century.
  assign part = PartW'(y1 >> 2) - PartW'(q1_q) + PartW'(q1_q >> 2)
              + PartW'(days_before(mm_q))
              + PartW'(leap_q && (mm_q > MonthFeb))
              + PartW'(dd_q) - PartW'(1);

  // Later start and earlier end bound the common span.
  assign lo    = (serial_q[0] > serial_q[2]) ? serial_q[0] : serial_q[2];
  assign hi    = (serial_q[1] < serial_q[3]) ? serial_q[1] : serial_q[3];
  assign count = (lo_q <= hi_q) ? CountW'(hi_q - lo_q + SerialW'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dates_q[0] <= '{day: in_i.a_start_day, month: in_i.a_start_month,
                      year: in_i.a_start_year};
      dates_q[1] <= '{day: in_i.a_end_day, month: in_i.a_end_month,
                      year: in_i.a_end_year};
      dates_q[2] <= '{day: in_i.b_start_day, month: in_i.b_start_month,
                      year: in_i.b_start_year};
      dates_q[3] <= '{day: in_i.b_end_day, month: in_i.b_end_month,
                      year: in_i.b_end_year};
    end
    case (state_q)
      ST_CLAMP: begin
        yy_q <= yy_clamp;
        mm_q <= mm_clamp;
        dd_q <= cur.day;
      end
      ST_MULQ: begin
        prod_q <= mul_p;
      end
      ST_LEAP: begin
        leap_q <= leap;
        q1_q   <= qy - QuotW'(rem == '0);
        dd_q   <= dd_clamp;
      end
      ST_MUL365: begin
        prod_q <= mul_p;
        part_q <= part;
      end
      ST_SUM: begin
        serial_q[idx_q] <= prod_q[SerialW-1:0] + SerialW'(part_q);
      end
      ST_CMP: begin
        lo_q <= lo;
        hi_q <= hi;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_q <= count;
    end
  end

`ifndef SYNTHESIS
  // A fresh transaction always starts with the first date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CLAMP) && (idx_q == '0))
    else $error("sequencer did not start at the first date");

  // The leap flag may only be set for a year divisible by four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL365) && leap_q |-> (yy_q[1:0] == 2'b00))
    else $error("leap flag set for a year not divisible by four");

  // The last serial step hands over to the compare step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) && last_date |=> (state_q == ST_CMP))
    else $error("compare step skipped after the fourth date");

  // A result is never dropped while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output register overwritten while full");

  // Empty overlap yields zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (lo_q > hi_q) |=> (out_q == '0))
    else $error("disjoint periods gave a nonzero count");
`endif

endmodule

>>> sim/tb.sv
// Testbench for date_period_overlap_days: drives pairs of date periods with
// random idling and back-pressure, and checks every day count it returns.
// Depends on dpod_pkg, the interfaces in dpod_if.sv and the block itself.
module tb
  import dpod_pkg::*;
();

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 7;
  // This margin lets a stray result show itself after the last expected one
  // has arrived.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned IdlePct     = 24;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned ShownFaults = 10;

  // One input transaction: period A and period B, each a start and an end.
  typedef struct packed {
    date_t a_start;
    date_t a_end;
    date_t b_start;
    date_t b_end;
  } period_pair_t;

  logic clk_i;
  logic rst_ni;

  dpod_in_if  in_if ();
  dpod_out_if out_if ();

  date_period_overlap_days dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // ---------------------------------------------------------------------
  // Calendar arithmetic used to predict the count.
  // ---------------------------------------------------------------------

  // Gregorian rule: every fourth year, but not centuries unless divisible
  // by four hundred.
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    int unsigned n;
    case (m)
      2:             n = leap ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // Serial day number with 0001-01-01 as day zero. Each field is first
  // pulled into its legal range: the year into 1..9999, the month into
  // 1..12 and the day into 1..length of that month.
  function automatic int unsigned day_number(input date_t d);
    int unsigned y;
    int unsigned m;
    int unsigned dd;
    int unsigned span;
    int unsigned prior;
    int unsigned n;
    bit          leap;
    y = d.year;
    if (y < 1) y = 1;
    if (y > 9999) y = 9999;
    m = d.month;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    leap = is_leap_year(y);
    span = days_in_month(m, leap);
    dd = d.day;
    if (dd < 1) dd = 1;
    if (dd > span) dd = span;
    prior = y - 1;
    n = 365 * prior + prior / 4 - prior / 100 + prior / 400;
    for (int unsigned k = 1; k < m; k++) n += days_in_month(k, leap);
    return n + dd - 1;
  endfunction

  // Days common to both inclusive periods; an empty intersection, whether
  // from disjoint periods or from a period that ends before it starts,
  // gives zero.
  function automatic logic [CountW-1:0] overlap_count(input period_pair_t p);
    int unsigned first;
    int unsigned last;
    int unsigned b_first;
    int unsigned b_last;
    first   = day_number(p.a_start);
    last    = day_number(p.a_end);
    b_first = day_number(p.b_start);
    b_last  = day_number(p.b_end);
    if (b_first > first) first = b_first;
    if (b_last < last) last = b_last;
    if (first > last) return '0;
    return CountW'(last - first + 1);
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: holds the predicted counts in acceptance order.
  // ---------------------------------------------------------------------
  class overlap_scoreboard;
    logic [CountW-1:0] expected_q[$];
    int unsigned       faults;

    function new();
      faults = 0;
    endfunction

    function void note_periods(input period_pair_t p);
      expected_q.push_back(overlap_count(p));
    endfunction

    function void check_count(input logic [CountW-1:0] got);
      logic [CountW-1:0] want;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= ShownFaults) begin
          $display("unexpected result: overlap_days %0d with nothing pending", got);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= ShownFaults) begin
          $display("overlap_days mismatch: expected %0d, actual %0d", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  overlap_scoreboard scoreboard;

  // Idling rates and the receiver hold-off request, shared by the
  // stimulus process and the receiver process.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned rx_hold_cycles;

  // ---------------------------------------------------------------------
  // Clock, watchdog and the receiving side.
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // A run that stalls for good is caught here rather than hanging.
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver changes ready on the falling edge only. A hold-off request
  // is counted down here, once per falling edge, with ready kept low
  // throughout so that the output register fills and the input stalls.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Results are taken at the rising edge, where valid and ready are both
  // settled from the previous falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      scoreboard.check_count(out_if.overlap_days);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic date_t date_of(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t r;
    r.day   = DayW'(d);
    r.month = MonthW'(m);
    r.year  = YearW'(y);
    return r;
  endfunction

  function automatic period_pair_t pair_of(input date_t as, input date_t ae,
                                           input date_t bs, input date_t be);
    period_pair_t p;
    p.a_start = as;
    p.a_end   = ae;
    p.b_start = bs;
    p.b_end   = be;
    return p;
  endfunction

  // A legal date somewhere in the years y0 .. y0 + span.
  function automatic date_t date_in_window(input int unsigned y0, input int unsigned span);
    int unsigned y;
    int unsigned m;
    y = y0 + $urandom_range(span);
    m = $urandom_range(12, 1);
    return date_of($urandom_range(days_in_month(m, is_leap_year(y)), 1), m, y);
  endfunction

  // A date built from the edges of each field, legal and out of range.
  function automatic date_t edge_date();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    case ($urandom_range(4))
      0:       d = 0;
      1:       d = 1;
      2:       d = $urandom_range(31, 28);
      default: d = 31;
    endcase
    case ($urandom_range(4))
      0:       m = 0;
      1:       m = 1;
      2:       m = 2;
      3:       m = 12;
      default: m = $urandom_range(15, 13);
    endcase
    case ($urandom_range(5))
      0:       y = 0;
      1:       y = 1;
      2:       y = 9999;
      3:       y = $urandom_range(16383, 10000);
      4:       y = 16383;
      default: y = 4 * $urandom_range(2499, 1);
    endcase
    return date_of(d, m, y);
  endfunction

  function automatic date_t raw_date();
    return date_of($urandom_range(31), $urandom_range(15), $urandom_range(16383));
  endfunction

  // Mostly well-formed periods drawn from one shared window of years, so
  // that the two periods often overlap; the rest are edge values and
  // unconstrained bits.
  function automatic period_pair_t random_periods();
    int unsigned  kind;
    int unsigned  span;
    int unsigned  y0;
    date_t        t;
    period_pair_t p;
    kind = $urandom_range(99);
    if (kind < 70) begin
      case ($urandom_range(9))
        0, 1, 2, 3: span = 0;
        4, 5, 6:    span = 1;
        7:          span = 3;
        8:          span = 40;
        default:    span = 9998;
      endcase
      y0 = $urandom_range(9999 - span, 1);
      p = pair_of(date_in_window(y0, span), date_in_window(y0, span),
                  date_in_window(y0, span), date_in_window(y0, span));
      // Most periods are put in order; the rest stay as drawn and may be
      // empty.
      if (day_number(p.a_start) > day_number(p.a_end) && $urandom_range(99) < 85) begin
        t = p.a_start;
        p.a_start = p.a_end;
        p.a_end = t;
      end
      if (day_number(p.b_start) > day_number(p.b_end) && $urandom_range(99) < 85) begin
        t = p.b_start;
        p.b_start = p.b_end;
        p.b_end = t;
      end
    end else if (kind < 85) begin
      p = pair_of(edge_date(), edge_date(), edge_date(), edge_date());
    end else begin
      p = pair_of(raw_date(), raw_date(), raw_date(), raw_date());
    end
    return p;
  endfunction

  // Offers one transaction and returns on the falling edge after it has
  // been accepted, with valid still high so that a following transaction
  // can be offered back to back. Called on a falling edge.
  task automatic send_periods(input period_pair_t p);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do begin
        @(negedge clk_i);
      end while ($urandom_range(99) < src_idle_pct);
    end
    in_if.a_start_day   <= p.a_start.day;
    in_if.a_start_month <= p.a_start.month;
    in_if.a_start_year  <= p.a_start.year;
    in_if.a_end_day     <= p.a_end.day;
    in_if.a_end_month   <= p.a_end.month;
    in_if.a_end_year    <= p.a_end.year;
    in_if.b_start_day   <= p.b_start.day;
    in_if.b_start_month <= p.b_start.month;
    in_if.b_start_year  <= p.b_start.year;
    in_if.b_end_day     <= p.b_end.day;
    in_if.b_end_month   <= p.b_end.month;
    in_if.b_end_year    <= p.b_end.year;
    in_if.valid         <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scoreboard.note_periods(p);
    @(negedge clk_i);
  endtask

  // Withdraws the sender until every outstanding count has come back. At
  // least one falling edge passes, so valid is never driven twice at once.
  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (scoreboard.pending() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    scoreboard     = new();
    src_idle_pct   = IdlePct;
    sink_idle_pct  = IdlePct;
    rx_hold_cycles = 0;

    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.a_start_day   = '0;
    in_if.a_start_month = '0;
    in_if.a_start_year  = '0;
    in_if.a_end_day     = '0;
    in_if.a_end_month   = '0;
    in_if.a_end_year    = '0;
    in_if.b_start_day   = '0;
    in_if.b_start_month = '0;
    in_if.b_start_year  = '0;
    in_if.b_end_day     = '0;
    in_if.b_end_month   = '0;
    in_if.b_end_year    = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed transactions. Identical single days overlap by one day.
    send_periods(pair_of(date_of(15, 6, 2024), date_of(15, 6, 2024),
                         date_of(15, 6, 2024), date_of(15, 6, 2024)));
    // Disjoint periods, A wholly before B.
    send_periods(pair_of(date_of(1, 1, 2020), date_of(31, 1, 2020),
                         date_of(1, 2, 2020), date_of(29, 2, 2020)));
    // Periods that touch on a single shared end day.
    send_periods(pair_of(date_of(1, 3, 2021), date_of(10, 3, 2021),
                         date_of(10, 3, 2021), date_of(20, 3, 2021)));
    // A contains B, and then B contains A.
    send_periods(pair_of(date_of(1, 1, 1999), date_of(31, 12, 2001),
                         date_of(28, 2, 2000), date_of(1, 3, 2000)));
    send_periods(pair_of(date_of(29, 2, 2000), date_of(1, 3, 2000),
                         date_of(1, 1, 1900), date_of(31, 12, 2100)));
    // A period whose start lies after its end is empty, on either side.
    send_periods(pair_of(date_of(2, 5, 2010), date_of(1, 5, 2010),
                         date_of(1, 1, 2000), date_of(31, 12, 2020)));
    send_periods(pair_of(date_of(1, 1, 2000), date_of(31, 12, 2020),
                         date_of(1, 1, 2015), date_of(31, 12, 2014)));
    // The whole calendar on both sides gives the largest count.
    send_periods(pair_of(date_of(1, 1, 1), date_of(31, 12, 9999),
                         date_of(1, 1, 1), date_of(31, 12, 9999)));
    // The same through clamping: zero fields and all-ones fields.
    send_periods(pair_of(date_of(0, 0, 0), date_of(31, 15, 16383),
                         date_of(0, 0, 0), date_of(31, 15, 16383)));
    // Every field zero: all four dates fall on the first day of year one.
    send_periods(pair_of(date_of(0, 0, 0), date_of(0, 0, 0),
                         date_of(0, 0, 0), date_of(0, 0, 0)));
    // Year above range read as 9999, month above range read as December.
    send_periods(pair_of(date_of(1, 13, 9999), date_of(31, 12, 12000),
                         date_of(20, 12, 10000), date_of(25, 14, 9999)));
    // Day beyond the month: February in a leap year, a century common year
    // and a four-hundredth year; a thirty-day month.
    send_periods(pair_of(date_of(31, 2, 2024), date_of(31, 3, 2024),
                         date_of(1, 2, 2024), date_of(31, 4, 2024)));
    send_periods(pair_of(date_of(1, 2, 1900), date_of(30, 2, 1900),
                         date_of(29, 2, 1900), date_of(1, 3, 1900)));
    send_periods(pair_of(date_of(1, 1, 2000), date_of(31, 2, 2000),
                         date_of(29, 2, 2000), date_of(31, 12, 2000)));
    send_periods(pair_of(date_of(31, 4, 2023), date_of(31, 6, 2023),
                         date_of(31, 9, 2023), date_of(31, 11, 2023)));
    // Day zero read as the first; month zero read as January.
    send_periods(pair_of(date_of(0, 3, 2022), date_of(5, 0, 2023),
                         date_of(1, 3, 2022), date_of(0, 1, 2023)));
    // A partial overlap across a year boundary.
    send_periods(pair_of(date_of(15, 12, 2099), date_of(15, 1, 2100),
                         date_of(1, 1, 2100), date_of(28, 2, 2100)));
    // A whole century against a whole four-hundred-year cycle.
    send_periods(pair_of(date_of(1, 1, 1601), date_of(31, 12, 2000),
                         date_of(1, 1, 1901), date_of(31, 12, 2000)));

    // Random transactions. Part way through, the receiver holds off for a
    // long stretch while the sender keeps offering, later the sender waits
    // for the block to drain, and one span runs with no idling at all.
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == 120) rx_hold_cycles = HoldCycles;
      if (i == 260) wait_until_drained();
      if (i >= 380 && i < 480) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = IdlePct;
        sink_idle_pct = IdlePct;
      end
      send_periods(random_periods());
    end

    in_if.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (scoreboard.faults == 0 && scoreboard.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dpod_pkg.sv
design/dpod_if.sv
design/date_period_overlap_days.sv
sim/tb.sv
